// ----- design/bplr_pkg.sv -----
// Shared types and constants for the button press qualifier.
// Holds the mode and event codes, the register indexes and the interface structs.
// No dependencies.
package bplr_pkg;

   localparam int unsigned BUTTON_WIDTH = 2;
   localparam int unsigned COUNT_WIDTH  = 8;
   localparam int unsigned PRESS_WIDTH  = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [BUTTON_WIDTH-1:0] BUTTON_NONE = 2'd0;

   // Reset values of the configuration registers.
   localparam logic [PRESS_WIDTH-1:0] PRESS_TICKS_RESET        = 4'd3;
   localparam logic [COUNT_WIDTH-1:0] LONG_TICKS_RESET         = 8'd30;
   localparam logic [COUNT_WIDTH-1:0] FIRST_REPEAT_TICKS_RESET = 8'd18;
   localparam logic [COUNT_WIDTH-1:0] REPEAT_INTERVAL_RESET    = 8'd7;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PRESS_TICKS        = 2'd0,
      CSR_LONG_TICKS         = 2'd1,
      CSR_FIRST_REPEAT_TICKS = 2'd2,
      CSR_REPEAT_INTERVAL    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_DOWN   = 4'b0010,
      MODE_LONG   = 4'b0100,
      MODE_REPEAT = 4'b1000
   } mode_type;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_LONG    = 2'd2,
      EV_REPEAT  = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [PRESS_WIDTH-1:0] press_ticks;
      logic [COUNT_WIDTH-1:0] long_ticks;
      logic [COUNT_WIDTH-1:0] first_repeat_ticks;
      logic [COUNT_WIDTH-1:0] repeat_interval;
   } config_type;

   typedef struct packed {
      mode_type                mode;
      logic [BUTTON_WIDTH-1:0] held_button;
      logic [COUNT_WIDTH-1:0]  tick_count;
   } state_type;

   typedef struct packed {
      logic                    emit;
      event_kind_type          kind;
      logic [BUTTON_WIDTH-1:0] button;
   } event_type;

endpackage

// ----- design/button_press_long_repeat_qualifier_unit.sv -----
// Top level of the button press qualifier with long press and auto-repeat.
// Depends on bplr_pkg, bplr_csr and bplr_step.
//
// Each accepted beat on the req_ channel is one tick's sample of which button
// is down (0 none, 1 select, 2 up, 3 down). The block qualifies a press once
// the same button has been seen on press_ticks consecutive ticks, reports a
// long press when the running count reaches long_ticks, starts auto-repeat
// first_repeat_ticks ticks later and then reports a repeat every
// repeat_interval ticks. Dropping the button, or switching to another one,
// reports a release for the held button; that sample is not counted. Each
// sample produces zero or one beat on the rsp_ channel carrying the event
// kind (0 press, 1 release, 2 long press, 3 repeat) and the button. The block
// takes one sample per clock cycle while results are taken: a sample is held
// in the input register, where the state update and event decision are made
// in a single pass, and an event is loaded into the result register as the
// sample leaves, which raises rsp_valid for the event beat. While a result
// waits and rsp_ready is low, the sample in the input register is held,
// whether it raises an event or not, and req_ready stays low while that
// register is occupied; with rsp_ready high the block takes a sample every
// cycle. Configuration registers are written through csr_wr_en, csr_index
// and csr_wr_data and should only be changed while no sample is in flight.
module button_press_long_repeat_qualifier_unit import bplr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BUTTON_WIDTH-1:0]    req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_event_kind,
   output logic [BUTTON_WIDTH-1:0]    rsp_event_button,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   config_type cfg;

   // Input register.
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [BUTTON_WIDTH-1:0] in_sample_ff;

   // Qualifier state.
   state_type state_ff;
   state_type state_next;
   event_type ev;

   // Result register.
   logic                    out_valid_ff;
   logic                    out_valid_in;
   event_kind_type          out_kind_ff;
   logic [BUTTON_WIDTH-1:0] out_button_ff;

   logic advance;
   logic req_beat;

   bplr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   bplr_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .sample     (in_sample_ff),
      .state_next (state_next),
      .ev         (ev)
   );

   // The sample in the input register is processed once the result register
   // is free or is being emptied this cycle, whether or not it raises an event.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && ev.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         state_ff.mode        <= MODE_IDLE;
         state_ff.held_button <= BUTTON_NONE;
         state_ff.tick_count  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_sample_ff <= req_sample;
      end
      if (advance && ev.emit) begin
         out_kind_ff   <= ev.kind;
         out_button_ff <= ev.button;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_event_button = out_button_ff;

   // Outside idle a button is always held.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != MODE_IDLE |-> state_ff.held_button != BUTTON_NONE)
      else $error("non-idle mode without a held button");

   // An event produced by the step logic always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      advance && ev.emit |=> out_valid_ff && out_button_ff == $past(ev.button))
      else $error("event lost on its way to the result register");

   // A release always returns the qualifier to a clean idle state.
   assert property (@(posedge clock) disable iff (reset)
      advance && ev.emit && ev.kind == EV_RELEASE |=>
         state_ff.mode == MODE_IDLE && state_ff.held_button == BUTTON_NONE &&
         state_ff.tick_count == '0)
      else $error("release did not clear the qualifier state");

   // A sample waiting in the input register is neither dropped nor overwritten.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_sample_ff))
      else $error("stalled sample was lost");

endmodule

// ----- design/bplr_csr.sv -----
// Configuration registers of the button press qualifier.
// Depends on bplr_pkg for the register indexes and the config struct.
module bplr_csr import bplr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data,
   output config_type                 cfg
);

   config_type cfg_ff;
   config_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PRESS_TICKS:        cfg_in.press_ticks = csr_wr_data[PRESS_WIDTH-1:0];
            CSR_LONG_TICKS:         cfg_in.long_ticks = csr_wr_data;
            CSR_FIRST_REPEAT_TICKS: cfg_in.first_repeat_ticks = csr_wr_data;
            CSR_REPEAT_INTERVAL:    cfg_in.repeat_interval = csr_wr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_ticks        <= PRESS_TICKS_RESET;
         cfg_ff.long_ticks         <= LONG_TICKS_RESET;
         cfg_ff.first_repeat_ticks <= FIRST_REPEAT_TICKS_RESET;
         cfg_ff.repeat_interval    <= REPEAT_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/bplr_step.sv -----
// Next-state and event logic for one sample of the button press qualifier.
// Purely combinational; depends on bplr_pkg for the mode, event and struct types.
module bplr_step import bplr_pkg::*; (
   input  config_type              cfg,
   input  state_type               state,
   input  logic [BUTTON_WIDTH-1:0] sample,
   output state_type               state_next,
   output event_type               ev
);

   logic [COUNT_WIDTH-1:0] count_inc;

   assign count_inc = state.tick_count + COUNT_WIDTH'(1);

   always_comb begin
      state_next = state;
      ev.emit    = 1'b0;
      ev.kind    = EV_PRESS;
      ev.button  = state.held_button;

      case (state.mode)
         MODE_IDLE: begin
            if (sample == BUTTON_NONE) begin
               state_next.held_button = BUTTON_NONE;
               state_next.tick_count  = '0;
            end else if (state.held_button == BUTTON_NONE || sample == state.held_button) begin
               // Same button as the one being counted, or the first one seen.
               state_next.held_button = sample;
               state_next.tick_count  = count_inc;
               if (count_inc >= COUNT_WIDTH'(cfg.press_ticks)) begin
                  state_next.mode = MODE_DOWN;
                  ev.emit   = 1'b1;
                  ev.kind   = EV_PRESS;
                  ev.button = sample;
               end
            end else begin
               // A different button restarts the count without a press check.
               state_next.held_button = sample;
               state_next.tick_count  = COUNT_WIDTH'(1);
            end
         end
         MODE_DOWN, MODE_LONG, MODE_REPEAT: begin
            if (sample != state.held_button) begin
               state_next.mode        = MODE_IDLE;
               state_next.held_button = BUTTON_NONE;
               state_next.tick_count  = '0;
               ev.emit = 1'b1;
               ev.kind = EV_RELEASE;
            end else begin
               state_next.tick_count = count_inc;
               if (state.mode == MODE_DOWN) begin
                  if (count_inc == cfg.long_ticks) begin
                     state_next.mode       = MODE_LONG;
                     state_next.tick_count = '0;
                     ev.emit = 1'b1;
                     ev.kind = EV_LONG;
                  end
               end else if (state.mode == MODE_LONG) begin
                  if (count_inc >= cfg.first_repeat_ticks) begin
                     state_next.mode       = MODE_REPEAT;
                     state_next.tick_count = '0;
                  end
               end else begin
                  if (count_inc >= cfg.repeat_interval) begin
                     state_next.tick_count = '0;
                     ev.emit = 1'b1;
                     ev.kind = EV_REPEAT;
                  end
               end
            end
         end
         default: begin
            state_next.mode        = MODE_IDLE;
            state_next.held_button = BUTTON_NONE;
            state_next.tick_count  = '0;
         end
      endcase
   end

endmodule

// ----- tb/bplr_checker.sv -----
// Checker for the button press qualifier: watches the req_, rsp_ and csr_ ports.
// Predicts the events of each accepted sample, compares each rsp_ beat with the oldest
// prediction and counts failures. Depends on bplr_pkg.
module bplr_checker import bplr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [BUTTON_WIDTH-1:0]    req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_event_kind,
   input  logic [BUTTON_WIDTH-1:0]    rsp_event_button,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data,
   input  logic                       run_done,
   output int unsigned                events_due,
   output int unsigned                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      event_kind_type          kind;
      logic [BUTTON_WIDTH-1:0] button;
   } button_event_type;

   // Shadow copy of the registers.
   logic [PRESS_WIDTH-1:0]  press_limit;
   logic [COUNT_WIDTH-1:0]  long_limit;
   logic [COUNT_WIDTH-1:0]  repeat_delay;
   logic [COUNT_WIDTH-1:0]  repeat_gap;

   // Shadow copy of the qualifier state.
   mode_type                qual_mode;
   logic [BUTTON_WIDTH-1:0] held_key;
   logic [COUNT_WIDTH-1:0]  run_ticks;

   button_event_type        due_events[$];
   int unsigned             errors;

   // Advances the shadow state by one tick; returns 1 when the tick raises an event.
   function automatic logic qualify_tick(input logic [BUTTON_WIDTH-1:0] sample,
                                         output button_event_type ev);
      ev.kind   = EV_PRESS;
      ev.button = held_key;
      if (qual_mode == MODE_IDLE) begin
         if (sample == BUTTON_NONE) begin
            held_key  = BUTTON_NONE;
            run_ticks = '0;
            return 1'b0;
         end
         if (held_key == BUTTON_NONE)
            held_key = sample;
         if (sample != held_key) begin
            held_key  = sample;
            run_ticks = 8'd1;
            return 1'b0;
         end
         run_ticks = run_ticks + 8'd1;
         if (run_ticks < {4'd0, press_limit})
            return 1'b0;
         qual_mode = MODE_DOWN;
         ev.button = held_key;
         return 1'b1;
      end

      // Any other button, or none, ends the hold; this sample is not counted.
      if (sample != held_key) begin
         ev.kind   = EV_RELEASE;
         qual_mode = MODE_IDLE;
         held_key  = BUTTON_NONE;
         run_ticks = '0;
         return 1'b1;
      end

      run_ticks = run_ticks + 8'd1;
      case (qual_mode)
         MODE_DOWN: begin
            if (run_ticks == long_limit) begin
               qual_mode = MODE_LONG;
               run_ticks = '0;
               ev.kind   = EV_LONG;
               return 1'b1;
            end
         end
         MODE_LONG: begin
            if (run_ticks >= repeat_delay) begin
               qual_mode = MODE_REPEAT;
               run_ticks = '0;
            end
         end
         default: begin
            if (run_ticks >= repeat_gap) begin
               run_ticks = '0;
               ev.kind   = EV_REPEAT;
               return 1'b1;
            end
         end
      endcase
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      button_event_type predicted;
      button_event_type oldest;
      if (reset) begin
         press_limit  = PRESS_TICKS_RESET;
         long_limit   = LONG_TICKS_RESET;
         repeat_delay = FIRST_REPEAT_TICKS_RESET;
         repeat_gap   = REPEAT_INTERVAL_RESET;
         qual_mode    = MODE_IDLE;
         held_key     = BUTTON_NONE;
         run_ticks    = '0;
         errors       = 0;
         due_events.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRESS_TICKS:        press_limit  = csr_wr_data[PRESS_WIDTH-1:0];
               CSR_LONG_TICKS:         long_limit   = csr_wr_data;
               CSR_FIRST_REPEAT_TICKS: repeat_delay = csr_wr_data;
               CSR_REPEAT_INTERVAL:    repeat_gap   = csr_wr_data;
               default: ;
            endcase
         end

         // Compare before predicting, so a beat at this edge never meets its own sample.
         if (rsp_valid && rsp_ready) begin
            if (due_events.size() == 0) begin
               $error("unexpected event beat: kind %0d button %0d",
                      rsp_event_kind, rsp_event_button);
               errors++;
            end else begin
               oldest = due_events.pop_front();
               if (rsp_event_kind !== oldest.kind) begin
                  $error("event_kind: expected %0d, got %0d", oldest.kind, rsp_event_kind);
                  errors++;
               end
               if (rsp_event_button !== oldest.button) begin
                  $error("event_button: expected %0d, got %0d",
                         oldest.button, rsp_event_button);
                  errors++;
               end
            end
         end

         if (req_valid && req_ready) begin
            if (qualify_tick(req_sample, predicted))
               due_events.push_back(predicted);
         end

         if (run_done && due_events.size() != 0) begin
            $error("%0d predicted events never arrived", due_events.size());
            errors += due_events.size();
            due_events.delete();
         end
      end
      events_due <= due_events.size();
      fail_count <= errors;
   end

endmodule

// ----- tb/tb.sv -----
// Testbench top for button_press_long_repeat_qualifier_unit: clock, reset, stimulus.
// Drives samples and register settings, idles both channels and gives the verdict.
// Depends on bplr_pkg, bplr_checker and the block itself.
module tb;
   import bplr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The whole run stays far below this; only a hang gets here.
   localparam int unsigned CYCLE_LIMIT     = 1000000;
   localparam int unsigned DRAIN_LIMIT     = 4000;
   // Margin for the last sample to leave the input register after acceptance.
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned HOLD_OFF_CYCLES = 300;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [BUTTON_WIDTH-1:0]    req_sample;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [1:0]                 rsp_event_kind;
   logic [BUTTON_WIDTH-1:0]    rsp_event_button;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;
   logic                       run_done;
   int unsigned                events_due;
   int unsigned                fail_count;
   int unsigned                cycle_count = 0;

   // Idle styles: 0 means back-to-back beats, 1 short gaps, 2 long gaps.
   int unsigned                sender_style;
   int unsigned                receiver_style;
   // Set once by the stimulus to ask the receiver for its long hold-off.
   bit                         hold_off_armed;

   button_press_long_repeat_qualifier_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_button (rsp_event_button),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   bplr_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_button (rsp_event_button),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .run_done         (run_done),
      .events_due       (events_due),
      .fail_count       (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Number of idle cycles before the next beat, according to the current style.
   function automatic int unsigned draw_wait(input int unsigned style);
      case (style)
         0:       return 0;
         1:       return $urandom_range(0, 3);
         default: return $urandom_range(0, 18);
      endcase
   endfunction

   // Offers one sample beat and returns once it has been taken. Valid is only
   // lowered when a gap is drawn, so back-to-back beats keep it high throughout.
   task automatic offer_sample(input logic [BUTTON_WIDTH-1:0] sample);
      int unsigned gap;
      gap = draw_wait(sender_style);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
   endtask

   // Waits until every predicted event has been delivered, then lets the last
   // sample that raised no event leave the pipeline.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (events_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers on consecutive cycles; the block must be idle.
   task automatic write_settings(input logic [PRESS_WIDTH-1:0] press_t,
                                 input logic [COUNT_WIDTH-1:0] long_t,
                                 input logic [COUNT_WIDTH-1:0] first_t,
                                 input logic [COUNT_WIDTH-1:0] period_t);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PRESS_TICKS;
      csr_wr_data <= {4'd0, press_t};
      @(negedge clock);
      csr_index   <= CSR_LONG_TICKS;
      csr_wr_data <= long_t;
      @(negedge clock);
      csr_index   <= CSR_FIRST_REPEAT_TICKS;
      csr_wr_data <= first_t;
      @(negedge clock);
      csr_index   <= CSR_REPEAT_INTERVAL;
      csr_wr_data <= period_t;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random stimulus made mostly of whole button holds: one button held for a
   // random number of ticks, then let go or replaced by another button. The
   // first hold of each phase lasts the full length, so that each phase
   // reaches its long press, and auto-repeat where the settings allow it
   // within that length. The rest is noise: short bursts of random samples.
   // Samples of no button in noise are idle ticks and do not count toward
   // the budget.
   task automatic run_sessions(input int unsigned budget, input int unsigned longest);
      int unsigned             counted;
      int unsigned             hold;
      int unsigned             burst;
      bit                      first;
      logic [BUTTON_WIDTH-1:0] key;
      logic [BUTTON_WIDTH-1:0] lift;
      counted = 0;
      first   = 1'b1;
      while (counted < budget) begin
         sender_style = $urandom_range(0, 2);
         if (first || $urandom_range(0, 4) != 0) begin
            key = BUTTON_WIDTH'($urandom_range(1, 3));
            if (first)
               hold = longest;
            else if ($urandom_range(0, 2) == 0)
               hold = $urandom_range(1, 20);
            else
               hold = $urandom_range(1, longest);
            first = 1'b0;
            if ($urandom_range(0, 1) == 0)
               lift = BUTTON_NONE;
            else
               lift = (key == 2'd3) ? 2'd1 : key + 2'd1;
            repeat (hold) offer_sample(key);
            offer_sample(lift);
            counted += hold + 1;
         end else begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               key = BUTTON_WIDTH'($urandom_range(0, 3));
               offer_sample(key);
               if (key != BUTTON_NONE)
                  counted++;
            end
         end
      end
   endtask

   // Receiver: before each event beat it stalls for a drawn number of cycles,
   // then holds ready high until a beat is taken. The style changes every 16
   // beats. Once armed, it holds ready low for a long stretch while samples
   // keep coming, so the result register fills and req_ready drops.
   initial begin
      int unsigned stall;
      int unsigned taken;
      bit          held_off;
      rsp_ready      = 1'b0;
      receiver_style = 2;
      taken          = 0;
      held_off       = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 16 == 0)
            receiver_style = $urandom_range(0, 2);
         @(negedge clock);
         if (hold_off_armed && !held_off) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            stall = draw_wait(receiver_style);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Main stimulus: directed ticks under the reset settings, then random
   // phases under settings that reach both extremes of all but long_ticks.
   initial begin
      logic [BUTTON_WIDTH-1:0] opening_ticks [22];
      int unsigned             guard;
      // Covers: no button in idle, a different button restarting the count,
      // a press of each button, release by no button and by another button,
      // and a count cleared by an empty tick before the press threshold.
      opening_ticks = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0,
                        2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd0};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample     = BUTTON_NONE;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_PRESS_TICKS;
      csr_wr_data    = '0;
      run_done       = 1'b0;
      hold_off_armed = 1'b0;
      sender_style   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_ticks[i]) begin
         sender_style = (i < 11) ? 0 : 2;
         offer_sample(opening_ticks[i]);
      end
      run_sessions(120, 60);

      // Small settings, with the long receiver hold-off: in auto-repeat
      // every tick raises an event, so the block backs up quickly.
      settle();
      write_settings(4'd1, 8'd16, 8'd1, 8'd1);
      hold_off_armed = 1'b1;
      run_sessions(100, 40);

      // Zero press, first-repeat and interval thresholds, which the block treats as one.
      settle();
      write_settings(4'd0, 8'd16, 8'd0, 8'd0);
      run_sessions(80, 30);

      // Long threshold below the press count: the count wraps before the
      // long press fires, and the full hold then reaches a few repeats.
      settle();
      write_settings(4'd15, 8'd5, 8'd3, 8'd2);
      run_sessions(270, 270);

      // Largest settings: the full hold reaches the long press at the top
      // of the count.
      settle();
      write_settings(4'd15, 8'd255, 8'd255, 8'd255);
      run_sessions(300, 300);

      // A few random settings in the useful range.
      repeat (3) begin
         settle();
         write_settings(PRESS_WIDTH'($urandom_range(1, 15)),
                        COUNT_WIDTH'($urandom_range(16, 48)),
                        COUNT_WIDTH'($urandom_range(1, 24)),
                        COUNT_WIDTH'($urandom_range(1, 12)));
         run_sessions(90, 90);
      end

      // Drain: every predicted event must arrive, then allow the pipeline to empty.
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (events_due != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      run_done <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- button_press_long_repeat_qualifier_unit.f -----
design/bplr_pkg.sv
design/bplr_csr.sv
design/bplr_step.sv
design/button_press_long_repeat_qualifier_unit.sv
tb/bplr_checker.sv
tb/tb.sv
